/* hw/rtl/dsl_pkg.sv */
package dsl_pkg;

  // Field widths.
  localparam int SHEET_W       = 12;
  localparam int NC_W          = 5;
  localparam int SEP_W         = 8;
  localparam int ALIGN_W       = 8;
  localparam int ALIGN_FIELD_W = 4;
  localparam int NUM_W         = 31;
  localparam int COORD_W       = 16;
  localparam int BOX_W         = 15;

  // Longest row of glyphs.
  localparam int MAX_DIGITS = 10;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int POS_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int DIGIT_W    = 4;
  localparam int MULT_N     = 9;
  localparam int STEP_W     = $clog2(64'd9 * (64'd10 ** (MAX_DIGITS - 1)) + 64'd1);
  localparam int CMP_W      = (STEP_W > NUM_W) ? STEP_W : NUM_W;

  // Layout arithmetic widths.
  localparam int TOTAL_W = $clog2(MAX_DIGITS * (2 ** SHEET_W - 1) +
                                  (MAX_DIGITS - 1) * (2 ** SEP_W - 1) + 1);
  localparam int DIFF_W  = ((TOTAL_W > BOX_W) ? TOTAL_W : BOX_W) + 1;
  localparam int X_W     = ((DIFF_W > COORD_W) ? DIFF_W : COORD_W) + 3;
  localparam int SRC_W   = DIGIT_W + SHEET_W;
  localparam int DIV_CNT_W = $clog2(SHEET_W + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SHEET_W;

  localparam logic [SHEET_W-1:0] RST_SHEET_WIDTH    = SHEET_W'(10);
  localparam logic [SHEET_W-1:0] RST_SHEET_HEIGHT   = SHEET_W'(1);
  localparam logic [NC_W-1:0]    RST_NUM_COMPONENTS = NC_W'(10);
  localparam logic [SEP_W-1:0]   RST_SEPARATION     = '0;
  localparam logic [ALIGN_W-1:0] RST_ALIGN_MODE     = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHEET_WIDTH    = 3'd0,
    CFG_SHEET_HEIGHT   = 3'd1,
    CFG_NUM_COMPONENTS = 3'd2,
    CFG_SEPARATION     = 3'd3,
    CFG_ALIGN_MODE     = 3'd4
  } cfg_reg_t;

  typedef enum logic [ALIGN_FIELD_W-1:0] {
    ALIGN_START  = 4'd0,
    ALIGN_CENTER = 4'd1,
    ALIGN_END    = 4'd2
  } align_t;

  // Row p, column d holds (d + 1) * 10**p.
  typedef logic [MAX_DIGITS-1:0][MULT_N-1:0][STEP_W-1:0] step_tbl_t;

  function automatic step_tbl_t build_step_tbl();
    step_tbl_t   t;
    logic [63:0] pw;
    pw = 64'd1;
    for (int p = 0; p < MAX_DIGITS; p++) begin
      for (int d = 0; d < MULT_N; d++) begin
        t[p][d] = STEP_W'(pw * 64'(d + 1));
      end
      pw = pw * 64'd10;
    end
    return t;
  endfunction

  localparam step_tbl_t STEP_TBL = build_step_tbl();

  // Commands from the controller and status back from the datapath.
  typedef struct packed {
    logic load;
    logic total;
    logic align;
    logic emit;
  } dsl_cmd_t;

  typedef struct packed {
    logic setup_done;
    logic out_free;
    logic last_pos;
  } dsl_status_t;

  localparam logic signed [X_W-1:0] COORD_MAX_X = X_W'(2 ** (COORD_W - 1) - 1);
  localparam logic signed [X_W-1:0] COORD_MIN_X = -(X_W'(2 ** (COORD_W - 1)));

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [X_W-1:0] v);
    logic signed [X_W-1:0] c;
    c = v;
    if (v > COORD_MAX_X) c = COORD_MAX_X;
    if (v < COORD_MIN_X) c = COORD_MIN_X;
    return c[COORD_W-1:0];
  endfunction

  function automatic logic [SHEET_W-1:0] sat_src(input logic [SRC_W-1:0] v);
    return (v > SRC_W'(2 ** SHEET_W - 1)) ? '1 : v[SHEET_W-1:0];
  endfunction

endpackage

/* hw/rtl/dsl_in_if.sv */
interface dsl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [dsl_pkg::NUM_W-1:0]            number_value;
  logic signed [dsl_pkg::COORD_W-1:0]   box_x;
  logic signed [dsl_pkg::COORD_W-1:0]   box_y;
  logic [dsl_pkg::BOX_W-1:0]            box_width;
  logic [dsl_pkg::BOX_W-1:0]            box_height;

  modport source (output valid, number_value, box_x, box_y, box_width, box_height,
                  input ready);
  modport sink   (input valid, number_value, box_x, box_y, box_width, box_height,
                  output ready);
endinterface

/* hw/rtl/dsl_out_if.sv */
interface dsl_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dsl_pkg::COORD_W-1:0]   dest_x;
  logic signed [dsl_pkg::COORD_W-1:0]   dest_y;
  logic [dsl_pkg::SHEET_W-1:0]          src_x;
  logic [dsl_pkg::SHEET_W-1:0]          src_y;
  logic [dsl_pkg::SHEET_W-1:0]          cell_width;
  logic [dsl_pkg::SHEET_W-1:0]          cell_height;
  logic                                 last_glyph;

  modport source (output valid, dest_x, dest_y, src_x, src_y, cell_width, cell_height,
                  last_glyph, input ready);
  modport sink   (input valid, dest_x, dest_y, src_x, src_y, cell_width, cell_height,
                  last_glyph, output ready);
endinterface

/* hw/rtl/dsl_divider.sv */
// Restoring divider, one quotient bit per cycle.
module dsl_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dsl_pkg::SHEET_W-1:0]  dividend,
  input  logic [dsl_pkg::NC_W-1:0]     divisor,
  output logic                         busy,
  output logic [dsl_pkg::SHEET_W-1:0]  quotient
);

  logic                              busy_r;
  logic [dsl_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [dsl_pkg::SHEET_W-1:0]       quo_r;
  logic [dsl_pkg::NC_W-1:0]          rem_r;
  logic [dsl_pkg::NC_W-1:0]          div_r;
  logic [dsl_pkg::NC_W:0]            trial;
  logic [dsl_pkg::NC_W:0]            trial_sub;
  logic                              ge;

  assign trial     = {rem_r, quo_r[dsl_pkg::SHEET_W-1]};
  assign ge        = trial >= {1'b0, div_r};
  assign trial_sub = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= dsl_pkg::DIV_CNT_W'(dsl_pkg::SHEET_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == dsl_pkg::DIV_CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[dsl_pkg::SHEET_W-2:0], ge};
      rem_r <= ge ? trial_sub[dsl_pkg::NC_W-1:0] : trial[dsl_pkg::NC_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

/* hw/rtl/dsl_datapath.sv */
module dsl_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dsl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dsl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [dsl_pkg::NUM_W-1:0]           number_value,
  input  logic signed [dsl_pkg::COORD_W-1:0]  box_x,
  input  logic signed [dsl_pkg::COORD_W-1:0]  box_y,
  input  logic [dsl_pkg::BOX_W-1:0]           box_width,
  input  logic [dsl_pkg::BOX_W-1:0]           box_height,
  input  dsl_pkg::dsl_cmd_t                   cmd,
  output dsl_pkg::dsl_status_t                status,
  dsl_out_if.source                           out_ch
);

  // Configuration registers.
  logic [dsl_pkg::SHEET_W-1:0] sheet_w_r;
  logic [dsl_pkg::SHEET_W-1:0] sheet_h_r;
  logic [dsl_pkg::NC_W-1:0]    nc_r;
  logic [dsl_pkg::SEP_W-1:0]   sep_r;
  logic [dsl_pkg::ALIGN_W-1:0] align_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sheet_w_r <= dsl_pkg::RST_SHEET_WIDTH;
      sheet_h_r <= dsl_pkg::RST_SHEET_HEIGHT;
      nc_r      <= dsl_pkg::RST_NUM_COMPONENTS;
      sep_r     <= dsl_pkg::RST_SEPARATION;
      align_r   <= dsl_pkg::RST_ALIGN_MODE;
    end else if (cfg_we) begin
      unique case (dsl_pkg::cfg_reg_t'(cfg_index))
        dsl_pkg::CFG_SHEET_WIDTH:    sheet_w_r <= cfg_data[dsl_pkg::SHEET_W-1:0];
        dsl_pkg::CFG_SHEET_HEIGHT:   sheet_h_r <= cfg_data[dsl_pkg::SHEET_W-1:0];
        dsl_pkg::CFG_NUM_COMPONENTS: nc_r      <= cfg_data[dsl_pkg::NC_W-1:0];
        dsl_pkg::CFG_SEPARATION:     sep_r     <= cfg_data[dsl_pkg::SEP_W-1:0];
        dsl_pkg::CFG_ALIGN_MODE:     align_r   <= cfg_data[dsl_pkg::ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sheet geometry; a component count of zero behaves as one.
  logic [dsl_pkg::NC_W-1:0]    nc_eff;
  logic                        vertical;
  logic                        div_busy;
  logic [dsl_pkg::SHEET_W-1:0] quotient;
  logic [dsl_pkg::SHEET_W-1:0] cw;
  logic [dsl_pkg::SHEET_W-1:0] ch;

  assign nc_eff   = (nc_r == '0) ? dsl_pkg::NC_W'(1) : nc_r;
  assign vertical = sheet_h_r > sheet_w_r;
  assign cw       = vertical ? sheet_w_r : quotient;
  assign ch       = vertical ? quotient : sheet_h_r;

  dsl_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .dividend (vertical ? sheet_h_r : sheet_w_r),
    .divisor  (nc_eff),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Item registers.
  logic [dsl_pkg::NUM_W-1:0]          rem_r;
  logic signed [dsl_pkg::COORD_W-1:0] bx_r;
  logic signed [dsl_pkg::COORD_W-1:0] by_r;
  logic [dsl_pkg::BOX_W-1:0]          bw_r;
  logic [dsl_pkg::BOX_W-1:0]          bh_r;
  logic                               single_r;

  // Digit count scan, one power of ten per cycle, from the top down.
  logic                        scanning_r;
  logic [dsl_pkg::POS_W-1:0]   scan_p_r;
  logic [dsl_pkg::CNT_W-1:0]   count_r;
  logic                        scan_hit;

  assign scan_hit = dsl_pkg::CMP_W'(rem_r) >=
                    dsl_pkg::CMP_W'(dsl_pkg::STEP_TBL[scan_p_r][0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r <= 1'b0;
    end else if (cmd.load) begin
      scanning_r <= (dsl_pkg::MAX_DIGITS > 1);
    end else if (scanning_r && (scan_hit || scan_p_r == dsl_pkg::POS_W'(1))) begin
      scanning_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_p_r <= dsl_pkg::POS_W'(dsl_pkg::MAX_DIGITS - 1);
      count_r  <= dsl_pkg::CNT_W'(1);
    end else if (scanning_r) begin
      if (scan_hit) begin
        count_r <= dsl_pkg::CNT_W'(scan_p_r) + dsl_pkg::CNT_W'(1);
      end else begin
        scan_p_r <= scan_p_r - 1'b1;
      end
    end
  end

  // Row setup.
  logic [dsl_pkg::CNT_W-1:0]          cnt_eff;
  logic [dsl_pkg::TOTAL_W-1:0]        cnt_t;
  logic [dsl_pkg::TOTAL_W-1:0]        total_nxt;
  logic [dsl_pkg::TOTAL_W-1:0]        total_r;
  logic [dsl_pkg::SHEET_W:0]          step_r;
  logic [dsl_pkg::POS_W-1:0]          pos_r;
  logic signed [dsl_pkg::X_W-1:0]     gx_r;
  logic signed [dsl_pkg::COORD_W-1:0] dy_r;

  assign cnt_eff   = single_r ? dsl_pkg::CNT_W'(1) : count_r;
  assign cnt_t     = dsl_pkg::TOTAL_W'(cnt_eff);
  assign total_nxt = cnt_t * dsl_pkg::TOTAL_W'(cw) +
                     (cnt_t - 1'b1) * dsl_pkg::TOTAL_W'(sep_r);

  // Alignment, halving truncated toward zero.
  logic signed [dsl_pkg::DIFF_W-1:0] diff_x;
  logic signed [dsl_pkg::DIFF_W-1:0] half_x;
  logic signed [dsl_pkg::DIFF_W-1:0] diff_y;
  logic signed [dsl_pkg::DIFF_W-1:0] half_y;
  logic signed [dsl_pkg::X_W-1:0]    bx_ext;
  logic signed [dsl_pkg::X_W-1:0]    by_ext;
  logic signed [dsl_pkg::X_W-1:0]    x_al;
  logic signed [dsl_pkg::X_W-1:0]    y_al;

  assign diff_x = $signed(dsl_pkg::DIFF_W'(bw_r)) - $signed(dsl_pkg::DIFF_W'(total_r));
  assign half_x = (diff_x + $signed(dsl_pkg::DIFF_W'(diff_x[dsl_pkg::DIFF_W-1]))) >>> 1;
  assign diff_y = $signed(dsl_pkg::DIFF_W'(bh_r)) - $signed(dsl_pkg::DIFF_W'(ch));
  assign half_y = (diff_y + $signed(dsl_pkg::DIFF_W'(diff_y[dsl_pkg::DIFF_W-1]))) >>> 1;
  assign bx_ext = dsl_pkg::X_W'(bx_r);
  assign by_ext = dsl_pkg::X_W'(by_r);

  always_comb begin
    unique case (dsl_pkg::align_t'(align_r[dsl_pkg::ALIGN_FIELD_W-1:0]))
      dsl_pkg::ALIGN_CENTER: x_al = bx_ext + dsl_pkg::X_W'(half_x);
      dsl_pkg::ALIGN_END:    x_al = bx_ext + dsl_pkg::X_W'(diff_x);
      default:               x_al = bx_ext;
    endcase
    unique case (dsl_pkg::align_t'(align_r[dsl_pkg::ALIGN_W-1:dsl_pkg::ALIGN_FIELD_W]))
      dsl_pkg::ALIGN_CENTER: y_al = by_ext + dsl_pkg::X_W'(half_y);
      dsl_pkg::ALIGN_END:    y_al = by_ext + dsl_pkg::X_W'(diff_y);
      default:               y_al = by_ext;
    endcase
  end

  // Digit at the current position: count the multiples of 10**pos that fit.
  logic [dsl_pkg::MULT_N-1:0]     ge;
  logic [dsl_pkg::DIGIT_W-1:0]    digit_raw;
  logic [dsl_pkg::DIGIT_W-1:0]    digit;
  logic [dsl_pkg::STEP_W-1:0]     sub;
  logic [dsl_pkg::NUM_W-1:0]      rem_nxt;
  logic [dsl_pkg::SRC_W-1:0]      src_full;
  logic [dsl_pkg::SHEET_W-1:0]    src_sat;

  always_comb begin
    digit_raw = '0;
    for (int d = 0; d < dsl_pkg::MULT_N; d++) begin
      ge[d] = dsl_pkg::CMP_W'(rem_r) >= dsl_pkg::CMP_W'(dsl_pkg::STEP_TBL[pos_r][d]);
      digit_raw = digit_raw + dsl_pkg::DIGIT_W'(ge[d]);
    end
  end

  assign digit    = single_r ? '0 : digit_raw;
  assign sub      = (digit == '0) ? '0 :
                    dsl_pkg::STEP_TBL[pos_r][dsl_pkg::DIGIT_W'(digit - 1'b1)];
  assign rem_nxt  = rem_r - dsl_pkg::NUM_W'(sub);
  assign src_full = dsl_pkg::SRC_W'(digit) * dsl_pkg::SRC_W'(vertical ? ch : cw);
  assign src_sat  = dsl_pkg::sat_src(src_full);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r    <= number_value;
      bx_r     <= box_x;
      by_r     <= box_y;
      bw_r     <= box_width;
      bh_r     <= box_height;
      single_r <= (nc_eff == dsl_pkg::NC_W'(1));
    end else if (cmd.emit) begin
      rem_r <= rem_nxt;
    end
    if (cmd.total) begin
      total_r <= total_nxt;
      step_r  <= {1'b0, cw} + (dsl_pkg::SHEET_W + 1)'(sep_r);
      pos_r   <= dsl_pkg::POS_W'(cnt_eff - 1'b1);
    end else if (cmd.emit) begin
      pos_r <= pos_r - 1'b1;
    end
    if (cmd.align) begin
      gx_r <= x_al;
      dy_r <= dsl_pkg::sat_coord(y_al);
    end else if (cmd.emit) begin
      gx_r <= gx_r + $signed(dsl_pkg::X_W'(step_r));
    end
  end

  // Output register.
  logic                               out_valid_r;
  logic signed [dsl_pkg::COORD_W-1:0] dest_x_r;
  logic signed [dsl_pkg::COORD_W-1:0] dest_y_r;
  logic [dsl_pkg::SHEET_W-1:0]        src_x_r;
  logic [dsl_pkg::SHEET_W-1:0]        src_y_r;
  logic [dsl_pkg::SHEET_W-1:0]        cell_w_r;
  logic [dsl_pkg::SHEET_W-1:0]        cell_h_r;
  logic                               last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      dest_x_r <= dsl_pkg::sat_coord(gx_r);
      dest_y_r <= dy_r;
      src_x_r  <= vertical ? '0 : src_sat;
      src_y_r  <= vertical ? src_sat : '0;
      cell_w_r <= cw;
      cell_h_r <= ch;
      last_r   <= (pos_r == '0);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.dest_x      = dest_x_r;
  assign out_ch.dest_y      = dest_y_r;
  assign out_ch.src_x       = src_x_r;
  assign out_ch.src_y       = src_y_r;
  assign out_ch.cell_width  = cell_w_r;
  assign out_ch.cell_height = cell_h_r;
  assign out_ch.last_glyph  = last_r;

  assign status.setup_done = !div_busy && !scanning_r;
  assign status.out_free   = !out_valid_r || out_ch.ready;
  assign status.last_pos   = (pos_r == '0);

endmodule

/* hw/rtl/dsl_ctrl.sv */
module dsl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dsl_pkg::dsl_status_t  status,
  output dsl_pkg::dsl_cmd_t     cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_TOTAL = 5'b00100,
    ST_ALIGN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        if (status.setup_done) state_nxt = ST_TOTAL;
      end
      ST_TOTAL: begin
        cmd.total = 1'b1;
        state_nxt = ST_ALIGN;
      end
      ST_ALIGN: begin
        cmd.align = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free && status.last_pos) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

/* hw/rtl/digit_sprite_layout_core.sv */
// Digit sprite layout core.
// A number and a target box arrive as one transaction on in_ch. The block
// counts the decimal digits, aligns the row of glyphs inside the box and
// sends one transaction per digit on out_ch, most significant digit first,
// with last_glyph set on the final one. Each result carries the glyph's
// destination corner, its cell offset in the sprite sheet and the cell size.
// Sheet geometry, glyph gap and alignment come from the cfg_ write port and
// must only change while the block is idle.
// Sequence: the cell size comes from a 12-step bit-serial divider, and the
// digit count scan runs alongside it. After that one result per cycle leaves
// the output register while the receiver keeps accepting, and the input side
// reopens once the last glyph is loaded.
// If the receiver stalls, the current result holds in the output register
// and the sequencer waits; nothing is dropped.
// Reset (rst_n low, synchronous) returns the sequencer to idle, empties the
// output register and loads the register reset values.
module digit_sprite_layout_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dsl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dsl_pkg::CFG_DATA_W-1:0]  cfg_data,
  dsl_in_if.sink                          in_ch,
  dsl_out_if.source                       out_ch
);

  dsl_pkg::dsl_cmd_t    cmd;
  dsl_pkg::dsl_status_t status;
  logic                 in_ready;

  // The sequencer owns the input handshake and steps the datapath.
  dsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the divider, the digit logic and
  // the output register.
  dsl_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .number_value (in_ch.number_value),
    .box_x        (in_ch.box_x),
    .box_y        (in_ch.box_y),
    .box_width    (in_ch.box_width),
    .box_height   (in_ch.box_height),
    .cmd          (cmd),
    .status       (status),
    .out_ch       (out_ch)
  );

  assign in_ch.ready = in_ready;

  // A glyph is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("glyph loaded into an occupied output register");

  // Setup must not report done right after an item is loaded.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !status.setup_done)
    else $error("setup reported done right after load");

  // Only one item is in flight.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input still open after a transaction");

  // Loading the last glyph reopens the input side.
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && status.last_pos) |=> in_ch.ready)
    else $error("input not reopened after the last glyph");

endmodule
